// File: sv/tagged_job_table_oldest_seen_evict_macros.svh
// Assertion helpers for the job table RTL.
`ifndef TAGGED_JOB_TABLE_OLDEST_SEEN_EVICT_MACROS_SVH
`define TAGGED_JOB_TABLE_OLDEST_SEEN_EVICT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define TJT_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define TJT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TJT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tjt_pkg.sv
package tjt_pkg;

    // Default table geometry
    localparam int ENTRIES_DEF      = 16;
    localparam int TAG_BITS_DEF     = 64;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Field widths on the stream ports
    localparam int OP_W    = 3;
    localparam int TAG_W   = 64;
    localparam int PAY_W   = 32;
    localparam int STATE_W = 8;
    localparam int IDX_W   = 4;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;
    localparam int AGE_W   = 32;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 120;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 3'd0,
        OP_MARK    = 3'd1,
        OP_SET     = 3'd2,
        OP_COUNT   = 3'd3,
        OP_GET     = 3'd4,
        OP_COMPACT = 3'd5,
        OP_CLEAR   = 3'd6
    } t_op;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture the request, clear scan accumulators
        logic scan;    // walk the occupied slots
        logic commit;  // apply the update and load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

// File: sv/tjt_ctrl.sv
module tjt_ctrl import tjt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state r_state;
    logic   r_ready;

    assign o_req_ready = r_ready;

    // Decode commands from state
    always_comb begin
        o_cmd.load   = r_ready && i_req_valid;
        o_cmd.scan   = (r_state == ST_SCAN);
        o_cmd.commit = (r_state == ST_DONE) && i_sts.out_free;
    end

    // Advance state, hold ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b1;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_cmd.load) begin
                        r_state <= ST_SCAN;
                        r_ready <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (i_sts.scan_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

// File: sv/tjt_dp.sv
`include "tagged_job_table_oldest_seen_evict_macros.svh"

module tjt_dp import tjt_pkg::*; #(
    parameter int ENTRIES      = ENTRIES_DEF,
    parameter int TAG_BITS     = TAG_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [OP_W-1:0]    i_op,
    input  logic [TAG_W-1:0]   i_tag,
    input  logic [PAY_W-1:0]   i_payload,
    input  logic [STATE_W-1:0] i_job_state,
    input  logic               i_seen,
    input  logic [IDX_W-1:0]   i_active_index,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_ok,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [CNT_W-1:0]   o_active_count,
    output logic [TAG_W-1:0]   o_tag,
    output logic [PAY_W-1:0]   o_payload,
    output logic [STATE_W-1:0] o_state
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // Table storage
    logic [TAG_BITS-1:0]     r_mem_tag  [ENTRIES];
    logic [PAYLOAD_BITS-1:0] r_mem_pay  [ENTRIES];
    logic [STATE_W-1:0]      r_mem_st   [ENTRIES];
    logic                    r_mem_seen [ENTRIES];
    logic [AGE_W-1:0]        r_mem_age  [ENTRIES];

    // Captured request
    t_op                     r_op;
    logic [TAG_BITS-1:0]     r_tag;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [STATE_W-1:0]      r_st;
    logic                    r_seen;
    logic [IDX_W-1:0]        r_idx;

    // Table bookkeeping
    logic [CW-1:0]    r_fill;
    logic [AGE_W-1:0] r_next_age;

    // Scan pipeline
    logic [CW-1:0]           r_iss;
    logic                    r_rd_vld;
    logic [IW-1:0]           r_rd_slot;
    logic [TAG_BITS-1:0]     r_rd_tag;
    logic [PAYLOAD_BITS-1:0] r_rd_pay;
    logic [STATE_W-1:0]      r_rd_st;
    logic                    r_rd_seen;
    logic [AGE_W-1:0]        r_rd_age;

    // Scan accumulators
    logic                    r_hit;
    logic [IW-1:0]           r_hit_slot;
    logic                    r_ev_vld;
    logic [IW-1:0]           r_ev_slot;
    logic [AGE_W-1:0]        r_ev_age;
    logic [CW-1:0]           r_uns;
    logic                    r_get_hit;
    logic [IW-1:0]           r_get_slot;
    logic [TAG_BITS-1:0]     r_get_tag;
    logic [PAYLOAD_BITS-1:0] r_get_pay;
    logic [STATE_W-1:0]      r_get_st;

    // Result register
    logic               r_m_valid;
    logic               r_m_ok;
    logic [SLOT_W-1:0]  r_m_slot;
    logic [CNT_W-1:0]   r_m_cnt;
    logic [TAG_W-1:0]   r_m_tag;
    logic [PAY_W-1:0]   r_m_pay;
    logic [STATE_W-1:0] r_m_st;

    logic                    issue;
    logic [IW-1:0]           rd_addr;
    logic                    cmp_wr;
    logic                    we_tag;
    logic                    we_pay;
    logic                    we_st;
    logic                    we_seen;
    logic                    we_age;
    logic [IW-1:0]           wr_addr;
    logic [TAG_BITS-1:0]     wr_tag;
    logic [PAYLOAD_BITS-1:0] wr_pay;
    logic [STATE_W-1:0]      wr_st;
    logic                    wr_seen;
    logic [AGE_W-1:0]        wr_age;
    logic [CW-1:0]           n_fill;
    logic [AGE_W-1:0]        n_next_age;
    logic                    res_ok;
    logic [IW-1:0]           res_slot;
    logic [CW-1:0]           res_cnt;
    logic                    res_fetch;

    assign issue   = i_cmd.scan && (r_iss < r_fill);
    assign rd_addr = r_iss[IW-1:0];
    assign cmp_wr  = r_rd_vld && (r_op == OP_COMPACT) && !r_rd_seen;

    assign o_sts.scan_done = i_cmd.scan && !issue && !r_rd_vld;
    assign o_sts.out_free  = !r_m_valid || i_ready;

    // Select table write and commit results
    always_comb begin
        we_tag     = 1'b0;
        we_pay     = 1'b0;
        we_st      = 1'b0;
        we_seen    = 1'b0;
        we_age     = 1'b0;
        wr_addr    = '0;
        wr_tag     = r_tag;
        wr_pay     = r_pay;
        wr_st      = r_st;
        wr_seen    = r_seen;
        wr_age     = r_next_age;
        n_fill     = r_fill;
        n_next_age = r_next_age;
        res_ok     = 1'b0;
        res_slot   = '0;
        res_cnt    = '0;
        res_fetch  = 1'b0;
        if (cmp_wr) begin
            // move an unseen record down to the compacted position
            {we_tag, we_pay, we_st, we_seen, we_age} = '1;
            wr_addr = r_uns[IW-1:0];
            wr_tag  = r_rd_tag;
            wr_pay  = r_rd_pay;
            wr_st   = r_rd_st;
            wr_seen = r_rd_seen;
            wr_age  = r_rd_age;
        end else if (i_cmd.commit) begin
            case (r_op)
                OP_WRITE: begin
                    if (r_hit) begin
                        {we_tag, we_pay, we_st, we_seen} = '1;
                        wr_addr  = r_hit_slot;
                        res_ok   = 1'b1;
                        res_slot = r_hit_slot;
                    end else if (r_fill < CW'(ENTRIES) || r_ev_vld) begin
                        {we_tag, we_pay, we_st, we_seen, we_age} = '1;
                        if (r_fill < CW'(ENTRIES)) begin
                            wr_addr = r_fill[IW-1:0];
                            n_fill  = r_fill + CW'(1);
                        end else begin
                            wr_addr = r_ev_slot;
                        end
                        res_ok   = 1'b1;
                        res_slot = wr_addr;
                        if (r_next_age != AGE_MAX) begin
                            n_next_age = r_next_age + AGE_W'(1);
                        end
                    end
                end
                OP_MARK: begin
                    if (r_hit) begin
                        we_seen  = 1'b1;
                        wr_seen  = 1'b1;
                        wr_addr  = r_hit_slot;
                        res_ok   = 1'b1;
                        res_slot = r_hit_slot;
                    end
                end
                OP_SET: begin
                    if (r_hit) begin
                        we_st    = 1'b1;
                        wr_addr  = r_hit_slot;
                        res_ok   = 1'b1;
                        res_slot = r_hit_slot;
                    end
                end
                OP_COUNT: begin
                    res_ok  = 1'b1;
                    res_cnt = r_uns;
                end
                OP_GET: begin
                    if (r_get_hit) begin
                        res_ok    = 1'b1;
                        res_slot  = r_get_slot;
                        res_fetch = 1'b1;
                    end
                end
                OP_COMPACT: begin
                    n_fill  = r_uns;
                    res_ok  = 1'b1;
                    res_cnt = r_uns;
                end
                OP_CLEAR: begin
                    n_fill     = '0;
                    n_next_age = '0;
                    res_ok     = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Write table
    always_ff @(posedge i_clk) begin
        if (we_tag) begin
            r_mem_tag[wr_addr] <= wr_tag;
        end
        if (we_pay) begin
            r_mem_pay[wr_addr] <= wr_pay;
        end
        if (we_st) begin
            r_mem_st[wr_addr] <= wr_st;
        end
        if (we_seen) begin
            r_mem_seen[wr_addr] <= wr_seen;
        end
        if (we_age) begin
            r_mem_age[wr_addr] <= wr_age;
        end
    end

    // Read table at the scan pointer
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_slot <= rd_addr;
            r_rd_tag  <= r_mem_tag[rd_addr];
            r_rd_pay  <= r_mem_pay[rd_addr];
            r_rd_st   <= r_mem_st[rd_addr];
            r_rd_seen <= r_mem_seen[rd_addr];
            r_rd_age  <= r_mem_age[rd_addr];
        end
    end

    // Capture request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_op);
            r_tag  <= i_tag[TAG_BITS-1:0];
            r_pay  <= PAYLOAD_BITS'(i_payload);
            r_st   <= i_job_state;
            r_seen <= i_seen;
            r_idx  <= i_active_index;
        end
    end

    // Accumulate tag match, eviction candidate and unseen records
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_iss     <= '0;
            r_hit     <= 1'b0;
            r_ev_vld  <= 1'b0;
            r_uns     <= '0;
            r_get_hit <= 1'b0;
        end else begin
            if (issue) begin
                r_iss <= r_iss + CW'(1);
            end
            if (r_rd_vld) begin
                if (!r_hit && r_rd_tag == r_tag) begin
                    r_hit      <= 1'b1;
                    r_hit_slot <= r_rd_slot;
                end
                // oldest seen record, lowest slot on equal age
                if (r_rd_seen && (!r_ev_vld || r_rd_age < r_ev_age)) begin
                    r_ev_vld  <= 1'b1;
                    r_ev_slot <= r_rd_slot;
                    r_ev_age  <= r_rd_age;
                end
                if (!r_rd_seen) begin
                    if (!r_get_hit && 32'(r_uns) == 32'(r_idx)) begin
                        r_get_hit  <= 1'b1;
                        r_get_slot <= r_rd_slot;
                        r_get_tag  <= r_rd_tag;
                        r_get_pay  <= r_rd_pay;
                        r_get_st   <= r_rd_st;
                    end
                    r_uns <= r_uns + CW'(1);
                end
            end
        end
    end

    // Hold bookkeeping, scan valid and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_next_age <= '0;
            r_rd_vld   <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (i_cmd.commit) begin
                r_fill     <= n_fill;
                r_next_age <= n_next_age;
                r_m_valid  <= 1'b1;
            end else if (i_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Load result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_m_ok   <= res_ok;
            r_m_slot <= SLOT_W'(res_slot);
            r_m_cnt  <= CNT_W'(res_cnt);
            r_m_tag  <= res_fetch ? TAG_W'(r_get_tag) : '0;
            r_m_pay  <= res_fetch ? PAY_W'(r_get_pay) : '0;
            r_m_st   <= res_fetch ? r_get_st : '0;
        end
    end

    assign o_valid        = r_m_valid;
    assign o_ok           = r_m_ok;
    assign o_slot         = r_m_slot;
    assign o_active_count = r_m_cnt;
    assign o_tag          = r_m_tag;
    assign o_payload      = r_m_pay;
    assign o_state        = r_m_st;

    `TJT_ASSERT_HOLDS(a_fill_bound, i_clk, i_rst_n, r_fill <= CW'(ENTRIES), "fill count beyond table size")
    `TJT_ASSERT_IMPLIES(a_read_in_fill, i_clk, i_rst_n, r_rd_vld, CW'(r_rd_slot) < r_fill, "scan read beyond fill count")
    `TJT_ASSERT_IMPLIES(a_compact_down, i_clk, i_rst_n, cmp_wr, r_uns <= CW'(r_rd_slot), "compaction writes above its source slot")
    `TJT_ASSERT_IMPLIES(a_commit_idle_scan, i_clk, i_rst_n, i_cmd.commit, !r_rd_vld && !issue, "commit while scan in flight")
    `TJT_ASSERT_NEXT(a_commit_result, i_clk, i_rst_n, i_cmd.commit, r_m_valid, "commit without result")

endmodule

// File: sv/tagged_job_table_oldest_seen_evict.sv
// Channel  Dir  tdata (low bit up)                            tuser
// s_axis   in   tag 64, payload 32, state 8, seen 1, index 4  operation 3
// m_axis   out  ok 1, slot 4, count 5, tag 64, payload 32,    -
//               state 8
//
// Each request scans the occupied slots through the single-port table
// read, one slot per cycle, before the next request is accepted.
// Reset clears fill count, age counter, scan valid and result valid; table contents stay as they are.
// A request is taken while the previous result still waits on m_axis; the
// result of the new one is held until the output register frees.
module tagged_job_table_oldest_seen_evict import tjt_pkg::*; #(
    parameter int ENTRIES      = ENTRIES_DEF,
    parameter int TAG_BITS     = TAG_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // record_tag, record_payload, job_state,
                                                  // seen_flag, active_index, zero pad
    input  logic [OP_W-1:0]       s_axis_tuser,   // operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // ok, slot, active_count, out_tag,
                                                  // out_payload, out_state, zero pad
);

    t_cmd               cmd;
    t_sts               sts;
    logic               res_ok;
    logic [SLOT_W-1:0]  res_slot;
    logic [CNT_W-1:0]   res_cnt;
    logic [TAG_W-1:0]   res_tag;
    logic [PAY_W-1:0]   res_pay;
    logic [STATE_W-1:0] res_st;

    tjt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tjt_dp #(
        .ENTRIES      (ENTRIES),
        .TAG_BITS     (TAG_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_op           (s_axis_tuser),
        .i_tag          (s_axis_tdata[63:0]),
        .i_payload      (s_axis_tdata[95:64]),
        .i_job_state    (s_axis_tdata[103:96]),
        .i_seen         (s_axis_tdata[104]),
        .i_active_index (s_axis_tdata[108:105]),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_ok           (res_ok),
        .o_slot         (res_slot),
        .o_active_count (res_cnt),
        .o_tag          (res_tag),
        .o_payload      (res_pay),
        .o_state        (res_st)
    );

    // Pack result fields, lowest first
    assign m_axis_tdata = {6'b0, res_st, res_pay, res_tag, res_cnt, res_slot, res_ok};

endmodule
